// ===== hw/rtl/es2cal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_pkg: shared types and constants
// Time-of-day beat carried from the front end through the queue, the packed
// calendar result and the queue sizing.
// ----------------------------------------------------------------------------
package es2cal_pkg;

	localparam int unsigned DAYS_W      = 16;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Whole days since the epoch plus the time of day.
	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [4:0]        hour_of_day;
		logic [5:0]        minute_of_hour;
		logic [5:0]        second_of_minute;
	} es2cal_tod_t;

	// One beat on the internal link between front end, queue and back end.
	typedef struct packed {
		logic        valid;
		es2cal_tod_t tod;
	} es2cal_beat_t;

	// Broken-down calendar time produced by the back end.
	typedef struct packed {
		logic [8:0] day_of_year;
		logic [2:0] weekday;
		logic [7:0] year_since_1900;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [5:0] second_of_minute;
	} es2cal_date_t;

endpackage

// ===== hw/rtl/es2cal_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_front: seconds splitter
// Five-stage pipeline that splits epoch seconds into whole days and the time
// of day, using reciprocal multiplies for the constant divisors.
// ----------------------------------------------------------------------------
module es2cal_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [31:0]              in_seconds,
	input  logic                     push_ready,
	output es2cal_pkg::es2cal_beat_t push
);

	// floor(x / 675) for x < 2^25, exact: 675 * M - 2^35 = 607 <= 2^10
	localparam logic [25:0] RECIP_675  = 26'd50903317;
	// floor(x / 15) for x < 2^15, shift 19
	localparam logic [15:0] RECIP_15A  = 16'd34953;
	// floor(x / 15) for x < 2^9, shift 13
	localparam logic [9:0]  RECIP_15B  = 10'd547;
	localparam logic [31:0] SEC_PER_DAY = 32'd86400;

	logic        en;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] t_s1, t_s2;
	logic [15:0] days_s1, days_s2, days_s3, days_s4, days_s5;
	logic [31:0] prod_s2;
	logic [16:0] sod_s3;
	logic [10:0] mtot_s3, mtot_s4;
	logic [5:0]  sec_s4, sec_s5, min_s5;
	logic [4:0]  hour_s4, hour_s5;

	logic [50:0] days_prod;
	logic [16:0] sod;
	logic [30:0] mtot_prod;
	logic [18:0] hour_prod;
	logic [16:0] sec_full;
	logic [10:0] min_full;

	// stall the whole pipe only when the last stage cannot push
	assign en       = !v_s5 || push_ready;
	assign in_ready = en;

	assign days_prod = 51'(in_seconds[31:7]) * 51'(RECIP_675);
	assign sod       = 17'(t_s2 - prod_s2);
	assign mtot_prod = 31'(sod[16:2]) * 31'(RECIP_15A);
	assign hour_prod = 19'(mtot_s3[10:2]) * 19'(RECIP_15B);
	assign sec_full  = sod_s3 - 17'(mtot_s3) * 17'd60;
	assign min_full  = mtot_s4 - 11'(hour_s4) * 11'd60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= in_seconds;
			days_s1 <= days_prod[50:35];
			t_s2    <= t_s1;
			days_s2 <= days_s1;
			prod_s2 <= 32'({16'd0, days_s1} * SEC_PER_DAY);
			days_s3 <= days_s2;
			sod_s3  <= sod;
			mtot_s3 <= mtot_prod[29:19];
			days_s4 <= days_s3;
			mtot_s4 <= mtot_s3;
			sec_s4  <= sec_full[5:0];
			hour_s4 <= hour_prod[17:13];
			days_s5 <= days_s4;
			sec_s5  <= sec_s4;
			hour_s5 <= hour_s4;
			min_s5  <= min_full[5:0];
		end
	end

	always_comb begin
		push.valid                = v_s5;
		push.tod.days             = days_s5;
		push.tod.hour_of_day      = hour_s5;
		push.tod.minute_of_hour   = min_s5;
		push.tod.second_of_minute = sec_s5;
	end

endmodule

// ===== hw/rtl/es2cal_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_queue: decoupling queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module es2cal_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  es2cal_pkg::es2cal_beat_t push,
	output logic                     push_ready,
	input  logic                     pop,
	output es2cal_pkg::es2cal_beat_t head
);

	localparam int unsigned AW = es2cal_pkg::QUEUE_AW;

	es2cal_pkg::es2cal_tod_t mem_q [es2cal_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          full, empty, do_push, do_pop;

	assign full       = count_q == (AW+1)'(es2cal_pkg::QUEUE_DEPTH);
	assign empty      = count_q == '0;
	assign push_ready = !full;
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.tod;
		end
	end

	always_comb begin
		head.valid = !empty;
		head.tod   = mem_q[rd_ptr_q];
	end

endmodule

// ===== hw/rtl/es2cal_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_back: civil date pipeline
// Seven-stage pipeline turning a day count into Gregorian year, month, day,
// weekday and day of year; the last stage is the output register.
// ----------------------------------------------------------------------------
module es2cal_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  es2cal_pkg::es2cal_beat_t head,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output es2cal_pkg::es2cal_date_t out_date
);

	localparam logic [19:0] DAY_SHIFT  = 20'd719468;   // 0000-03-01 to epoch
	localparam logic [19:0] ERA4_START = 20'd584388;   // 4 * 146097
	localparam logic [19:0] ERA5_START = 20'd730485;   // 5 * 146097
	localparam logic [17:0] RECIP_7    = 18'd149797;   // shift 20
	localparam logic [16:0] RECIP_365A = 17'd91930;    // shift 25, x < 2^16
	localparam logic [18:0] RECIP_365B = 19'd367720;   // shift 27, x < 2^18
	localparam logic [11:0] RECIP_153  = 12'd3427;     // shift 19, x < 2^11

	// first day of each March-based month, (153 * m + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	es2cal_pkg::es2cal_tod_t tod_s1, tod_s2, tod_s3, tod_s4, tod_s5, tod_s6;
	logic        era5_s1, era5_s2, era5_s3, era5_s4;
	logic [17:0] doe_s1, doe_s2, doe_s3, doe_s4;
	logic [16:0] wx_s1;
	logic [13:0] wq_s1;
	logic [6:0]  a_s2;
	logic [2:0]  b_s2;
	logic        c_s2;
	logic [2:0]  wday_s2, wday_s3, wday_s4, wday_s5, wday_s6;
	logic [17:0] num_s3;
	logic [8:0]  yoe_s4;
	logic [11:0] year_s5, year_s6;
	logic [8:0]  doy_s5, doy_s6;
	logic [3:0]  mp_s6;
	es2cal_pkg::es2cal_date_t date_s7;

	logic [19:0] z;
	logic        era5;
	logic [16:0] wx;
	logic [34:0] wq_prod;
	logic [32:0] a_prod;
	logic [2:0]  b_cnt;
	logic [16:0] wrem;
	logic [36:0] yoe_prod;
	logic [1:0]  ycent;
	logic [17:0] yoe_days;
	logic [17:0] doy_full;
	logic [10:0] mp_num;
	logic [22:0] mp_prod;
	logic        leap;
	logic [8:0]  mday_full;
	es2cal_pkg::es2cal_date_t date_next;

	assign en  = !v_s7 || out_ready;
	assign pop = en;

	// stage 1: era and day of era, weekday quotient
	assign z       = 20'(head.tod.days) + DAY_SHIFT;
	assign era5    = z >= ERA5_START;
	assign wx      = 17'(head.tod.days) + 17'd4;
	assign wq_prod = 35'(wx) * 35'(RECIP_7);

	// stage 2: correction terms of the year-of-era formula, weekday remainder
	assign a_prod = 33'(doe_s1[17:2]) * 33'(RECIP_365A);
	always_comb begin
		if (doe_s1 >= 18'd146096) begin
			b_cnt = 3'd4;
		end else if (doe_s1 >= 18'd109572) begin
			b_cnt = 3'd3;
		end else if (doe_s1 >= 18'd73048) begin
			b_cnt = 3'd2;
		end else if (doe_s1 >= 18'd36524) begin
			b_cnt = 3'd1;
		end else begin
			b_cnt = 3'd0;
		end
	end
	assign wrem = wx_s1 - 17'(wq_s1) * 17'd7;

	// stage 4: year of era
	assign yoe_prod = 37'(num_s3) * 37'(RECIP_365B);

	// stage 5: year and March-based day of year
	always_comb begin
		if (yoe_s4 >= 9'd300) begin
			ycent = 2'd3;
		end else if (yoe_s4 >= 9'd200) begin
			ycent = 2'd2;
		end else if (yoe_s4 >= 9'd100) begin
			ycent = 2'd1;
		end else begin
			ycent = 2'd0;
		end
	end
	assign yoe_days = 18'(yoe_s4) * 18'd365 + 18'(yoe_s4[8:2]) - 18'(ycent);
	assign doy_full = doe_s4 - yoe_days;

	// stage 6: March-based month
	assign mp_num  = 11'(doy_s5) * 11'd5 + 11'd2;
	assign mp_prod = 23'(mp_num) * 23'(RECIP_153);

	// stage 7: final fields. March-based years reach 1969..2105 only, so the
	// sole century year seen that is not a leap year is 2100.
	assign leap      = (year_s6[1:0] == 2'd0) && (year_s6 != 12'd2100);
	assign mday_full = doy_s6 - month_start(mp_s6) + 9'd1;
	always_comb begin
		date_next.second_of_minute = tod_s6.second_of_minute;
		date_next.minute_of_hour   = tod_s6.minute_of_hour;
		date_next.hour_of_day      = tod_s6.hour_of_day;
		date_next.day_of_month     = mday_full[4:0];
		date_next.weekday          = wday_s6;
		if (mp_s6 < 4'd10) begin
			date_next.month_index     = mp_s6 + 4'd2;
			date_next.year_since_1900 = 8'(year_s6 - 12'd1900);
			date_next.day_of_year     = doy_s6 + 9'd59 + 9'(leap);
		end else begin
			date_next.month_index     = mp_s6 - 4'd10;
			date_next.year_since_1900 = 8'(year_s6 + 12'd1 - 12'd1900);
			date_next.day_of_year     = doy_s6 - 9'd306;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= head.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tod_s1  <= head.tod;
			era5_s1 <= era5;
			doe_s1  <= 18'(z - (era5 ? ERA5_START : ERA4_START));
			wx_s1   <= wx;
			wq_s1   <= wq_prod[33:20];

			tod_s2  <= tod_s1;
			era5_s2 <= era5_s1;
			doe_s2  <= doe_s1;
			a_s2    <= a_prod[31:25];
			b_s2    <= b_cnt;
			c_s2    <= doe_s1 == 18'd146096;
			wday_s2 <= wrem[2:0];

			tod_s3  <= tod_s2;
			era5_s3 <= era5_s2;
			doe_s3  <= doe_s2;
			num_s3  <= doe_s2 - 18'(a_s2) + 18'(b_s2) - 18'(c_s2);
			wday_s3 <= wday_s2;

			tod_s4  <= tod_s3;
			era5_s4 <= era5_s3;
			doe_s4  <= doe_s3;
			yoe_s4  <= yoe_prod[35:27];
			wday_s4 <= wday_s3;

			tod_s5  <= tod_s4;
			year_s5 <= 12'(yoe_s4) + (era5_s4 ? 12'd2000 : 12'd1600);
			doy_s5  <= doy_full[8:0];
			wday_s5 <= wday_s4;

			tod_s6  <= tod_s5;
			year_s6 <= year_s5;
			doy_s6  <= doy_s5;
			mp_s6   <= mp_prod[22:19];
			wday_s6 <= wday_s5;

			date_s7 <= date_next;
		end
	end

	assign out_valid = v_s7;
	assign out_date  = date_s7;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: epoch seconds to UTC calendar date
// Converts unsigned seconds since 1970-01-01 00:00:00 UTC into second,
// minute, hour, Gregorian day, month, year, weekday and day of year.
// ----------------------------------------------------------------------------
// Usage: the block takes one timestamp beat per clock while s_axis_tready is
// high and returns exactly one result beat per input beat, in order. With no
// backpressure the sustained rate is one beat per cycle. A five-stage front
// end splits the seconds into whole days and time of day, a four-entry queue
// decouples it from a seven-stage back end that turns the day count into the
// civil date; each pipe stalls as a whole only when its downstream side is
// full, so a slow sink fills the queue before s_axis_tready drops. All constant
// divisions are reciprocal multiplies of at most 25 by 26 bits, one per stage.
// Every 32-bit input is legal (up to 2106-02-07). There is no configuration
// and no state beyond the pipeline itself.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] epoch_seconds
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
	// [21:17] day_of_month, [25:22] month_index, [33:26] year_since_1900,
	// [36:34] weekday, [45:37] day_of_year, [47:46] zero
	output logic [47:0] m_axis_tdata
);

	es2cal_pkg::es2cal_beat_t push, head;
	es2cal_pkg::es2cal_date_t date;
	logic                     push_ready;
	logic                     pop;

	// Split seconds into days and time of day.
	es2cal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_seconds (s_axis_tdata),
		.push_ready (push_ready),
		.push       (push)
	);

	// Hold beats while the back end is stalled.
	es2cal_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head)
	);

	// Turn the day count into the civil date; last stage drives the port.
	es2cal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_date  (date)
	);

	// Pack the result beat, second_of_minute in the lowest bits.
	assign m_axis_tdata = {2'b00,
		date.day_of_year,
		date.weekday,
		date.year_since_1900,
		date.month_index,
		date.day_of_month,
		date.hour_of_day,
		date.minute_of_hour,
		date.second_of_minute};

endmodule

// ===== hw/rtl/es2cal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_checker: port-level checks
// Field ranges of result beats, output hold under stall, and input stall
// only behind a stalled output.
// ----------------------------------------------------------------------------
module es2cal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// hold the result beat while the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed under stall");

	// time-of-day and month fields in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60)
			&& (m_axis_tdata[16:12] < 5'd24) && (m_axis_tdata[25:22] < 4'd12))
		else $error("time or month field out of range");

	// date fields in range, padding zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[21:17] != 5'd0) && (m_axis_tdata[36:34] < 3'd7)
			&& (m_axis_tdata[45:37] <= 9'd365) && (m_axis_tdata[33:26] >= 8'd70)
			&& (m_axis_tdata[47:46] == 2'b00))
		else $error("date field out of range");

	// input stalls only while the output side is backed up
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending result");

endmodule

bind epoch_seconds_to_calendar_core es2cal_checker u_es2cal_checker (.*);
